>>> design/cpr_pkg.sv
// Shared types and constants for the clock page replacement block.
package cpr_pkg;

   localparam int FRAME_W            = 8;
   localparam int COUNT_W            = 9;
   localparam int MAX_FRAMES_DEFAULT = 256;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

   localparam logic ACT_ACCESS = 1'b0;
   localparam logic ACT_EVICT  = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_TEST
   } state_type;

   typedef struct packed {
      logic clear;
      logic set_bit;
      logic wrap_hand;
      logic read;
      logic step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic bit_set;
      logic clear_last;
   } status_type;

endpackage

>>> design/clock_page_replacement_core.sv
// Top level of the clock (second-chance) page replacement block.
//
// Request channel: raise start with req_action and req_frame; the word is
// taken at the edge where start is high and busy is low. Action access sets
// the reference bit of req_frame (frames at or above the frame count are
// dropped) and gives no response; busy stays low.
// Action evict sweeps from the clock hand. Each step reads the bit at the
// hand from the bit memory (state ST_READ) and tests it (state ST_TEST); a set bit
// is cleared and the hand advances. An evict holds busy through one such step
// for each of the k set bits swept (k at most the frame count) and a final
// read and test; the response word is on rsp_strobe and rsp_victim_frame for one
// cycle, registered from the final test; the next request may already be taken.
// Configuration: csr_write_enable with csr_write_data loads the frame count
// (0 reads as 1, values above MAX_FRAMES read as MAX_FRAMES); write it idle.
// Reset sets the hand to zero and the count to 256, then a clearing pass over
// the MAX_FRAMES entries zeroes all reference bits with busy held high.
// The receiver cannot stall; each response word is valid for one cycle only.
module clock_page_replacement_core #(
   parameter int MAX_FRAMES = cpr_pkg::MAX_FRAMES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_action,
   input  logic [cpr_pkg::FRAME_W-1:0] req_frame,
   output logic                        rsp_strobe,
   output logic [cpr_pkg::FRAME_W-1:0] rsp_victim_frame,
   input  logic                        csr_write_enable,
   input  logic [cpr_pkg::COUNT_W-1:0] csr_write_data
);
   import cpr_pkg::*;

   cmd_type    cmd;
   status_type status;

   cpr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy)
   );

   cpr_datapath #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_frame        (req_frame),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_victim_frame (rsp_victim_frame)
   );

`ifndef SYNTHESIS
   a_strobe_after_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response word without a preceding sweep");

   a_scan_end_strobes: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(cmd.clear)) |-> rsp_strobe)
      else $error("sweep ended without a response word");

   a_access_single_cycle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_action == ACT_ACCESS)) |=> (!busy && !rsp_strobe))
      else $error("access word started a sweep or a response");

   a_evict_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_action == ACT_EVICT)) |=> busy)
      else $error("evict word did not start a sweep");
`endif

endmodule

>>> design/cpr_ctrl.sv
// Controller state machine sequencing accesses and eviction sweeps.
module cpr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               req_action,
   input  cpr_pkg::status_type status,
   output cpr_pkg::cmd_type    cmd,
   output logic               busy
);
   import cpr_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      busy          = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               if (req_action == ACT_EVICT) begin
                  cmd.wrap_hand = 1'b1;
                  state_in      = ST_READ;
               end else begin
                  cmd.set_bit = 1'b1;
               end
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_TEST;
         end
         ST_TEST: begin
            if (status.bit_set) begin
               cmd.step = 1'b1;
               state_in = ST_READ;
            end else begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> design/cpr_datapath.sv
// Reference bits, clock hand, frame count register and result register.
module cpr_datapath #(
   parameter int MAX_FRAMES = cpr_pkg::MAX_FRAMES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cpr_pkg::cmd_type              cmd,
   output cpr_pkg::status_type           status,
   input  logic [cpr_pkg::FRAME_W-1:0]   req_frame,
   input  logic                          csr_write_enable,
   input  logic [cpr_pkg::COUNT_W-1:0]   csr_write_data,
   output logic                          rsp_strobe,
   output logic [cpr_pkg::FRAME_W-1:0]   rsp_victim_frame
);
   import cpr_pkg::*;

   localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int N_W   = $clog2(MAX_FRAMES + 1);
   localparam int EXT_W = (N_W > COUNT_W) ? N_W : COUNT_W;

   logic [COUNT_W-1:0]    frame_count_ff;
   logic                  ref_mem [MAX_FRAMES];
   logic                  rd_bit_ff;
   logic [IDX_W-1:0]      clr_ff;
   logic [IDX_W-1:0]      clr_in;
   logic [IDX_W-1:0]      hand_ff;
   logic [IDX_W-1:0]      hand_in;
   logic                  rsp_strobe_ff;
   logic [FRAME_W-1:0]    rsp_victim_ff;

   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic                     wr_bit;
   logic [EXT_W-1:0]         count_ext;
   logic [EXT_W-1:0]         n_eff;
   logic [EXT_W-1:0]         frame_ext;
   logic [EXT_W-1:0]         hand_ext;
   logic [EXT_W-1:0]         hand_next_ext;
   logic [IDX_W+FRAME_W-1:0] hand_wide;

   always_comb begin
      count_ext = EXT_W'(frame_count_ff);
      if (count_ext == '0) begin
         n_eff = EXT_W'(1);
      end else if (count_ext > EXT_W'(MAX_FRAMES)) begin
         n_eff = EXT_W'(MAX_FRAMES);
      end else begin
         n_eff = count_ext;
      end
   end

   assign frame_ext     = EXT_W'(req_frame);
   assign hand_ext      = EXT_W'(hand_ff);
   assign hand_next_ext = hand_ext + EXT_W'(1);
   assign hand_wide     = {{FRAME_W{1'b0}}, hand_ff};

   assign status.bit_set    = rd_bit_ff;
   assign status.clear_last = (clr_ff == IDX_W'(MAX_FRAMES - 1));

   always_comb begin
      hand_in = hand_ff;
      clr_in  = clr_ff;
      wr_en   = 1'b0;
      wr_addr = hand_ff;
      wr_bit  = 1'b0;
      if (cmd.clear) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         clr_in  = clr_ff + IDX_W'(1);
      end
      if (cmd.set_bit && (frame_ext < n_eff)) begin
         wr_en   = 1'b1;
         wr_addr = frame_ext[IDX_W-1:0];
         wr_bit  = 1'b1;
      end
      if (cmd.wrap_hand && (hand_ext >= n_eff)) begin
         hand_in = '0;
      end
      if (cmd.step) begin
         wr_en   = 1'b1;
         wr_addr = hand_ff;
         wr_bit  = 1'b0;
         if (hand_next_ext >= n_eff) begin
            hand_in = '0;
         end else begin
            hand_in = hand_next_ext[IDX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= COUNT_RESET;
         clr_ff         <= '0;
         hand_ff        <= '0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            frame_count_ff <= csr_write_data;
         end
         clr_ff        <= clr_in;
         hand_ff       <= hand_in;
         rsp_strobe_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ref_mem[wr_addr] <= wr_bit;
      end
      if (cmd.read) begin
         rd_bit_ff <= ref_mem[hand_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_victim_ff <= hand_wide[FRAME_W-1:0];
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_victim_frame = rsp_victim_ff;

endmodule

>>> verif/tb_top.sv
// Testbench for clock_page_replacement_core with a clock-sweep predictor.
module tb_top;
   import cpr_pkg::*;

   localparam int STALL_LIMIT = 3000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_action = ACT_ACCESS;
   logic [FRAME_W-1:0] req_frame = '0;
   logic               rsp_strobe;
   logic [FRAME_W-1:0] rsp_victim_frame;
   logic               csr_write_enable = 1'b0;
   logic [COUNT_W-1:0] csr_write_data = '0;

   bit                 ref_bit [MAX_FRAMES_DEFAULT];
   int unsigned        sweep_hand = 0;
   logic [COUNT_W-1:0] frame_count_reg = COUNT_RESET;
   logic [FRAME_W-1:0] victim_q [$];
   logic [FRAME_W-1:0] want_victim;
   int                 mismatches = 0;
   int                 stall_cycles = 0;
   bit                 idle_on = 1'b0;

   clock_page_replacement_core uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_frame        (req_frame),
      .rsp_strobe       (rsp_strobe),
      .rsp_victim_frame (rsp_victim_frame),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic int unsigned live_frames();
      int unsigned n;
      n = frame_count_reg;
      if (n == 0) n = 1;
      if (n > MAX_FRAMES_DEFAULT) n = MAX_FRAMES_DEFAULT;
      return n;
   endfunction

   function automatic void mark_frame(input logic [FRAME_W-1:0] f);
      if (f < live_frames()) ref_bit[f] = 1'b1;
   endfunction

   function automatic logic [FRAME_W-1:0] pick_victim();
      int unsigned n;
      int unsigned guard;
      n = live_frames();
      if (sweep_hand >= n) sweep_hand = 0;
      guard = 0;
      while (guard <= n && ref_bit[sweep_hand]) begin
         ref_bit[sweep_hand] = 1'b0;
         sweep_hand++;
         if (sweep_hand >= n) sweep_hand = 0;
         guard++;
      end
      return sweep_hand[FRAME_W-1:0];
   endfunction

   // compare each victim word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (victim_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected victim word: actual %0d", rsp_victim_frame);
         end else begin
            want_victim = victim_q.pop_front();
            if (rsp_victim_frame !== want_victim) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("victim_frame mismatch: expected %0d actual %0d",
                           want_victim, rsp_victim_frame);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
         $display("clock_page_replacement_core test failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_word(input logic act, input logic [FRAME_W-1:0] f);
      int gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 18);
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start      = 1'b1;
      req_action = act;
      req_frame  = f;
      do @(posedge clock); while (busy);
      if (act == ACT_EVICT) victim_q.push_back(pick_victim());
      else mark_frame(f);
   endtask

   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (victim_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_count(input logic [COUNT_W-1:0] v);
      drain();
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data   = v;
      @(negedge clock);
      csr_write_enable = 1'b0;
      frame_count_reg  = v;
   endtask

   task automatic test_reset_state();
      send_word(ACT_EVICT, 8'd0);
      send_word(ACT_ACCESS, 8'd0);
      send_word(ACT_ACCESS, 8'd1);
      send_word(ACT_ACCESS, 8'd255);
      send_word(ACT_EVICT, 8'd255);
      send_word(ACT_ACCESS, 8'd2);
      send_word(ACT_ACCESS, 8'd3);
      send_word(ACT_EVICT, 8'd0);
   endtask

   // hand beyond the new count, out-of-range frames, full wrap of the sweep
   task automatic test_small_counts();
      write_count(9'd3);
      send_word(ACT_ACCESS, 8'd0);
      send_word(ACT_ACCESS, 8'd3);
      send_word(ACT_ACCESS, 8'd200);
      send_word(ACT_EVICT, 8'd0);
      send_word(ACT_ACCESS, 8'd1);
      send_word(ACT_ACCESS, 8'd2);
      send_word(ACT_ACCESS, 8'd0);
      send_word(ACT_EVICT, 8'd0);
      write_count(9'd0);
      send_word(ACT_ACCESS, 8'd1);
      send_word(ACT_ACCESS, 8'd0);
      send_word(ACT_EVICT, 8'd0);
   endtask

   task automatic test_large_count();
      write_count(9'h1FF);
      send_word(ACT_ACCESS, 8'd255);
      send_word(ACT_ACCESS, 8'd254);
      send_word(ACT_EVICT, 8'd0);
   endtask

   task automatic random_phase(input logic [COUNT_W-1:0] cnt, input int words,
                               input bit idle_en);
      logic               act;
      logic [FRAME_W-1:0] f;
      write_count(cnt);
      for (int i = 0; i < words; i++) begin
         if (i % 16 == 0) idle_on = idle_en && ($urandom_range(0, 2) != 0);
         act = ($urandom_range(0, 99) < 30) ? ACT_EVICT : ACT_ACCESS;
         if ($urandom_range(0, 4) == 0) f = FRAME_W'($urandom_range(0, 255));
         else f = FRAME_W'($urandom_range(0, live_frames() - 1));
         send_word(act, f);
      end
   endtask

   task automatic test_random();
      random_phase(9'd256, 60, 1'b1);
      random_phase(9'd1, 30, 1'b1);
      random_phase(9'd2, 40, 1'b1);
      random_phase(9'd0, 20, 1'b1);
      random_phase(COUNT_W'($urandom_range(257, 511)), 40, 1'b1);
      random_phase(9'd7, 40, 1'b1);
      random_phase(9'd255, 50, 1'b1);
      random_phase(COUNT_W'($urandom_range(3, 200)), 60, 1'b1);
      random_phase(9'd256, 110, 1'b0);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_state();
      test_small_counts();
      test_large_count();
      test_random();
      drain();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && victim_q.size() == 0) begin
         $display("clock_page_replacement_core test passed");
      end else begin
         $display("clock_page_replacement_core test failed");
      end
      $finish;
   end

endmodule

>>> sim.f
design/cpr_pkg.sv
design/cpr_ctrl.sv
design/cpr_datapath.sv
design/clock_page_replacement_core.sv
verif/tb_top.sv
